// ===== rtl/cea_pkg.sv =====
// Shared types and constants for the column entropy accumulator.
package cea_pkg;

    localparam int ENTROPY_FRAC_BITS_DEF = 24;
    localparam int CNT_W   = 32;
    localparam int COL_W   = 16;
    localparam int SUM_W   = 40;
    localparam int STEP_W  = 5;
    localparam int LO_W    = 18;
    localparam int FIFO_DEPTH = 2;

    typedef enum logic [1:0]
    {
        KIND_CALC,
        KIND_ZERO,
        KIND_ERR
    } kind_t;

    typedef struct packed
    {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] total;
        logic             last;
        kind_t            kind;
    } item_t;

    typedef struct packed
    {
        logic push;
        logic full;
    } fifo_wr_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_NORM,
        ST_LOG,
        ST_DIV,
        ST_MUL_A,
        ST_MUL_B,
        ST_ACC
    } state_t;

endpackage

// ===== rtl/cea_fifo.sv =====
// Two-entry request queue between front and back.
module cea_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  cea_pkg::fifo_wr_t wr,
    input  cea_pkg::item_t    wr_item,
    input  logic              pop,
    output logic              empty,
    output logic              full,
    output cea_pkg::item_t    head
);
    import cea_pkg::*;

    item_t      mem_reg [FIFO_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign empty = (fill_reg == 2'd0);
    assign full  = (fill_reg == 2'(FIFO_DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr.push && !full)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (wr.push && !full)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(wr.push && !full) - 2'(pop && !empty);
        end
    end

endmodule

// ===== rtl/cea_front.sv =====
// Input side: takes requests and classifies each count.
module cea_front
(
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [2*cea_pkg::CNT_W-1:0]   s_tdata,
    input  logic                          s_tlast,
    input  logic                          q_full,
    output cea_pkg::fifo_wr_t             wr,
    output cea_pkg::item_t                wr_item
);
    import cea_pkg::*;

    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] tot;

    assign cnt      = s_tdata[CNT_W-1:0];
    assign tot      = s_tdata[2*CNT_W-1:CNT_W];
    assign s_tready = !q_full;
    assign wr.push  = s_tvalid && !q_full;
    assign wr.full  = q_full;

    always_comb
    begin
        wr_item.count = cnt;
        wr_item.total = tot;
        wr_item.last  = s_tlast;
        if (tot == '0 || cnt > tot)
        begin
            wr_item.kind = KIND_ERR;
        end
        else if (cnt == '0 || cnt == tot)
        begin
            wr_item.kind = KIND_ZERO;
        end
        else
        begin
            wr_item.kind = KIND_CALC;
        end
    end

endmodule

// ===== rtl/cea_back.sv =====
// Back end: log2 unit, divider, multiplies and the saturating accumulator.
module cea_back #(
    parameter int FRAC_BITS = cea_pkg::ENTROPY_FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  cea_pkg::item_t                head,
    output logic                          pop,
    input  logic [cea_pkg::COL_W-1:0]     num_columns,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cea_pkg::CNT_W+cea_pkg::COL_W-1:0] m_tdata,
    output logic                          m_tuser
);
    import cea_pkg::*;

    localparam int LW = STEP_W + FRAC_BITS;
    localparam int HW = LW - LO_W;
    localparam int AW = CNT_W + LO_W;
    localparam int BW = CNT_W + HW;
    localparam int TW = BW + 1 - (32 - LO_W);

    state_t state_reg, state_next;
    item_t  item_reg;

    logic [CNT_W-1:0]     x_reg;
    logic [STEP_W-1:0]    e_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 phase_reg;
    logic [LW-1:0]        lt_reg;
    logic [LW-1:0]        d_reg;
    logic [CNT_W:0]       rem_reg;
    logic [CNT_W-1:0]     q_reg;
    logic [AW-1:0]        a_reg;
    logic [BW-1:0]        b_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic                 err_reg;
    logic [COL_W-1:0]     col_reg;
    logic                 out_valid_reg;
    logic [CNT_W-1:0]     out_ent_reg;
    logic [COL_W-1:0]     out_col_reg;
    logic                 out_bad_reg;

    logic [2*CNT_W-1:0]   sq;
    logic [CNT_W:0]       sq_sh;
    logic [CNT_W-1:0]     m_new;
    logic [FRAC_BITS-1:0] frac_new;
    logic [LW-1:0]        l_new;
    logic [CNT_W:0]       rem2;
    logic                 ge;
    logic [BW:0]          tsum;
    logic [TW-1:0]        term;
    logic [SUM_W:0]       sum_add;
    logic [SUM_W-1:0]     sum_new;
    logic                 bad_new;
    logic [COL_W:0]       col_inc;
    logic                 acc_fire;
    logic                 log_done;

    assign sq       = x_reg * x_reg;
    assign sq_sh    = sq[2*CNT_W-1:CNT_W-1];
    assign m_new    = sq_sh[CNT_W] ? sq_sh[CNT_W:1] : sq_sh[CNT_W-1:0];
    assign frac_new = {frac_reg[FRAC_BITS-2:0], sq_sh[CNT_W]};
    assign l_new    = {e_reg, frac_new};
    assign log_done = (step_reg == STEP_W'(FRAC_BITS - 1));

    assign rem2 = {rem_reg[CNT_W-1:0], 1'b0};
    assign ge   = (rem2 >= {1'b0, item_reg.total});

    assign tsum = (BW+1)'(b_reg) + (BW+1)'(a_reg >> LO_W);
    assign term = (item_reg.kind == KIND_CALC) ? TW'(tsum >> (32 - LO_W)) : '0;
    assign sum_add = {1'b0, sum_reg} + (SUM_W+1)'(term);
    assign sum_new = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    assign bad_new = err_reg || (item_reg.kind == KIND_ERR);
    assign col_inc = {1'b0, col_reg} + (COL_W+1)'(1);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_col_reg, out_ent_reg};
    assign m_tuser  = out_bad_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = (head.kind == KIND_CALC) ? ST_NORM : ST_ACC;
                end
            end
            ST_NORM:
            begin
                if (x_reg[CNT_W-1])
                begin
                    state_next = ST_LOG;
                end
            end
            ST_LOG:
            begin
                if (log_done)
                begin
                    state_next = phase_reg ? ST_DIV : ST_NORM;
                end
            end
            ST_DIV:
            begin
                if (step_reg == '1)
                begin
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A: state_next = ST_MUL_B;
            ST_MUL_B: state_next = ST_ACC;
            ST_ACC:
            begin
                if (acc_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        acc_fire = 1'b0;
        case (state_reg)
            ST_IDLE: pop = !q_empty;
            ST_ACC:  acc_fire = !item_reg.last || !out_valid_reg || m_tready;
            default:
            begin
                pop      = 1'b0;
                acc_fire = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                item_reg  <= head;
                x_reg     <= head.total;
                e_reg     <= '1;
                phase_reg <= 1'b0;
            end
            ST_NORM:
            begin
                step_reg <= '0;
                frac_reg <= '0;
                if (!x_reg[CNT_W-1])
                begin
                    if (x_reg[CNT_W-1:CNT_W-8] == '0)
                    begin
                        x_reg <= x_reg << 8;
                        e_reg <= e_reg - STEP_W'(8);
                    end
                    else
                    begin
                        x_reg <= x_reg << 1;
                        e_reg <= e_reg - STEP_W'(1);
                    end
                end
            end
            ST_LOG:
            begin
                frac_reg <= frac_new;
                if (!log_done)
                begin
                    x_reg    <= m_new;
                    step_reg <= step_reg + STEP_W'(1);
                end
                else
                begin
                    step_reg <= '0;
                    if (!phase_reg)
                    begin
                        lt_reg    <= l_new;
                        x_reg     <= item_reg.count;
                        e_reg     <= '1;
                        phase_reg <= 1'b1;
                    end
                    else
                    begin
                        d_reg   <= (lt_reg > l_new) ? (lt_reg - l_new) : '0;
                        rem_reg <= {1'b0, item_reg.count};
                    end
                end
            end
            ST_DIV:
            begin
                rem_reg  <= ge ? (rem2 - {1'b0, item_reg.total}) : rem2;
                q_reg    <= {q_reg[CNT_W-2:0], ge};
                step_reg <= step_reg + STEP_W'(1);
            end
            ST_MUL_A: a_reg <= q_reg * d_reg[LO_W-1:0];
            ST_MUL_B: b_reg <= q_reg * d_reg[LW-1:LO_W];
            default:
            begin
            end
        endcase
        if (acc_fire && item_reg.last)
        begin
            out_ent_reg <= (sum_new > SUM_W'(32'hFFFF_FFFF)) ? '1 : sum_new[CNT_W-1:0];
            out_col_reg <= col_reg;
            out_bad_reg <= bad_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            err_reg       <= 1'b0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (acc_fire && item_reg.last)
            begin
                sum_reg       <= '0;
                err_reg       <= 1'b0;
                out_valid_reg <= 1'b1;
                col_reg <= (col_inc >= {1'b0, num_columns}) ? '0 : col_inc[COL_W-1:0];
            end
            else
            begin
                if (m_tready)
                begin
                    out_valid_reg <= 1'b0;
                end
                if (acc_fire)
                begin
                    sum_reg <= sum_new;
                    err_reg <= bad_new;
                end
            end
        end
    end

endmodule

// ===== rtl/column_entropy_accumulator.sv =====
// Top level of the column entropy accumulator.
// Base-2 Shannon entropy per column, Q8.24 output (fraction width set by
// ENTROPY_FRAC_BITS). Each count request goes through one shared sequencer:
// a load step, then normalize and square-iterate log2 of the total, then of
// the count (normalize steps, then one square iteration per fraction bit),
// a bit-serial divide, two multiplies and one accumulate step; zero, full
// and bad counts go straight from the load step to the accumulate step.
// The accumulate step of a column's last count waits while the previous
// column sits unread in the result register. A two-entry queue lets the
// input side keep taking requests meanwhile.
module column_entropy_accumulator #(
    parameter int ENTROPY_FRAC_BITS = cea_pkg::ENTROPY_FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // tdata: count[31:0], column_total[63:32]; tlast: last_in_column
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [2*cea_pkg::CNT_W-1:0]   s_tdata,
    input  logic                          s_tlast,
    // tdata: entropy[31:0], column_index[47:32]; tuser: bad_input
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cea_pkg::CNT_W+cea_pkg::COL_W-1:0] m_tdata,
    output logic                          m_tuser,
    // num_columns
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cea_pkg::COL_W-1:0]     cfg_data
);
    import cea_pkg::*;

    fifo_wr_t         wr;
    item_t            wr_item;
    item_t            head;
    logic             q_empty;
    logic             q_full;
    logic             pop;
    logic [COL_W-1:0] num_columns_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_columns_reg <= COL_W'(1);
        end
        else if (cfg_valid)
        begin
            num_columns_reg <= cfg_data;
        end
    end

    cea_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .wr       (wr),
        .wr_item  (wr_item)
    );

    cea_fifo u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .wr_item (wr_item),
        .pop     (pop),
        .empty   (q_empty),
        .full    (q_full),
        .head    (head)
    );

    cea_back #(
        .FRAC_BITS (ENTROPY_FRAC_BITS)
    ) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .head        (head),
        .pop         (pop),
        .num_columns (num_columns_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule
